// ----- rtl/tcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // field and address widths
    localparam int ACT_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = 16;
    localparam int OFFSET_W = 11;
    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int SUM_W    = ADDR_W + 1;

    // cell contents
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0]        TEXT_ATTR  = 8'h0F;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_MAC = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCR_RD,
        S_SCR_WR,
        S_CLEAR,
        S_OFFSET
    } t_state;

    typedef struct packed {
        t_alu_op           op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- rtl/tcc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, read before write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/tcc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcc_alu (
    input  wire tcc_pkg::t_alu_req               i_req,
    output logic [tcc_pkg::SUM_W-1:0]            o_sum
);

    // shared address unit: plain add, or row times columns plus column
    always_comb begin
        unique case (i_req.op)
            tcc_pkg::ALU_ADD: begin
                o_sum = tcc_pkg::SUM_W'(i_req.a) + tcc_pkg::SUM_W'(i_req.b);
            end
            tcc_pkg::ALU_MAC: begin
                o_sum = (tcc_pkg::SUM_W'(i_req.a) * tcc_pkg::SUM_W'(tcc_pkg::COLUMNS))
                        + tcc_pkg::SUM_W'(i_req.b);
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tcc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcc_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [tcc_pkg::ACT_W-1:0]      i_action,
    input  wire logic [tcc_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcc_pkg::ROW_W-1:0]      i_read_row,
    input  wire logic [tcc_pkg::COL_W-1:0]      i_read_column,
    input  wire logic [tcc_pkg::CELL_W-1:0]     i_ram_rdata,
    output tcc_pkg::t_ram_req                   o_ram,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic [tcc_pkg::COL_W-1:0]           o_cursor_column,
    output logic [tcc_pkg::ROW_W-1:0]           o_cursor_row,
    output logic [tcc_pkg::OFFSET_W-1:0]        o_cursor_offset,
    output logic [tcc_pkg::CELL_W-1:0]          o_cell_value
);

    localparam logic [tcc_pkg::ADDR_W-1:0] LAST_ADDR =
        tcc_pkg::ADDR_W'(tcc_pkg::CELL_COUNT - 1);
    localparam logic [tcc_pkg::ADDR_W-1:0] COPY_LAST =
        tcc_pkg::ADDR_W'(tcc_pkg::CELL_COUNT - tcc_pkg::COLUMNS - 1);

    tcc_pkg::t_state                  r_state,  n_state;
    logic [tcc_pkg::COL_W-1:0]        r_col,    n_col;
    logic [tcc_pkg::ROW_W-1:0]        r_row,    n_row;
    logic [tcc_pkg::ADDR_W-1:0]       r_addr,   n_addr;
    tcc_pkg::t_action                 r_action, n_action;
    logic [tcc_pkg::CHAR_W-1:0]       r_char,   n_char;
    logic [tcc_pkg::ROW_W-1:0]        r_rrow,   n_rrow;
    logic [tcc_pkg::COL_W-1:0]        r_rcol,   n_rcol;
    logic [tcc_pkg::CELL_W-1:0]       r_cell,   n_cell;
    logic [tcc_pkg::OFFSET_W-1:0]     r_off,    n_off;
    logic                             r_valid,  n_valid;

    tcc_pkg::t_alu_req                alu_req;
    logic [tcc_pkg::SUM_W-1:0]        alu_sum;

    // put decode
    logic [tcc_pkg::COL_W-1:0]        put_col;
    logic [tcc_pkg::ROW_W-1:0]        put_row;
    logic [tcc_pkg::COL_W-1:0]        put_col_eff;
    logic                             put_we;
    logic [tcc_pkg::CELL_W-1:0]       put_data;
    logic                             put_scroll;
    logic                             read_in_range;

    tcc_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    // state and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcc_pkg::S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_addr  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_addr  <= n_addr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_char   <= n_char;
        r_rrow   <= n_rrow;
        r_rcol   <= n_rcol;
        r_cell   <= n_cell;
        r_off    <= n_off;
    end

    // cursor movement for a put word
    always_comb begin
        put_col     = r_col;
        put_row     = r_row;
        put_col_eff = r_col;
        put_we      = 1'b0;
        put_data    = tcc_pkg::BLANK_CELL;
        unique case (r_char)
            tcc_pkg::CH_NEWLINE: begin
                put_col = '0;
                put_row = r_row + tcc_pkg::ROW_W'(1);
            end
            tcc_pkg::CH_RETURN: begin
                put_col = '0;
            end
            tcc_pkg::CH_BACKSPACE: begin
                if (r_col != '0) begin
                    put_col     = r_col - tcc_pkg::COL_W'(1);
                    put_col_eff = r_col - tcc_pkg::COL_W'(1);
                    put_we      = 1'b1;
                end
            end
            tcc_pkg::CH_TAB: begin
                put_col = (r_col + tcc_pkg::COL_W'(4)) & ~tcc_pkg::COL_W'(3);
            end
            default: begin
                put_we   = 1'b1;
                put_data = {tcc_pkg::TEXT_ATTR, r_char};
                put_col  = r_col + tcc_pkg::COL_W'(1);
            end
        endcase
        // wrap at row end
        if (put_col >= tcc_pkg::COL_W'(tcc_pkg::COLUMNS)) begin
            put_col = '0;
            put_row = put_row + tcc_pkg::ROW_W'(1);
        end
        put_scroll = (put_row >= tcc_pkg::ROW_W'(tcc_pkg::ROWS));
    end

    assign read_in_range = (r_rrow < tcc_pkg::ROW_W'(tcc_pkg::ROWS)) &&
                           (r_rcol < tcc_pkg::COL_W'(tcc_pkg::COLUMNS));

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_addr   = r_addr;
        n_action = r_action;
        n_char   = r_char;
        n_rrow   = r_rrow;
        n_rcol   = r_rcol;
        n_cell   = r_cell;
        n_off    = r_off;
        n_valid  = 1'b0;

        alu_req.op = tcc_pkg::ALU_ADD;
        alu_req.a  = r_addr;
        alu_req.b  = tcc_pkg::ADDR_W'(1);

        o_ram.we    = 1'b0;
        o_ram.addr  = alu_sum[tcc_pkg::ADDR_W-1:0];
        o_ram.wdata = tcc_pkg::BLANK_CELL;

        unique case (r_state)
            // blank the screen after reset
            tcc_pkg::S_INIT: begin
                o_ram.we   = 1'b1;
                o_ram.addr = r_addr;
                n_addr     = alu_sum[tcc_pkg::ADDR_W-1:0];
                if (r_addr == LAST_ADDR) begin
                    n_state = tcc_pkg::S_IDLE;
                end
            end
            tcc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_action = tcc_pkg::t_action'(i_action);
                    n_char   = i_char_code;
                    n_rrow   = i_read_row;
                    n_rcol   = i_read_column;
                    n_state  = tcc_pkg::S_EXEC;
                end
            end
            tcc_pkg::S_EXEC: begin
                n_cell     = '0;
                alu_req.op = tcc_pkg::ALU_MAC;
                unique case (r_action)
                    tcc_pkg::ACT_PUT: begin
                        alu_req.a   = tcc_pkg::ADDR_W'(r_row);
                        alu_req.b   = tcc_pkg::ADDR_W'(put_col_eff);
                        o_ram.we    = put_we;
                        o_ram.wdata = put_data;
                        n_col       = put_col;
                        if (put_scroll) begin
                            n_row   = tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1);
                            n_addr  = '0;
                            n_state = tcc_pkg::S_SCR_RD;
                        end else begin
                            n_row   = put_row;
                            n_state = tcc_pkg::S_OFFSET;
                        end
                    end
                    tcc_pkg::ACT_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_addr  = '0;
                        n_state = tcc_pkg::S_CLEAR;
                    end
                    tcc_pkg::ACT_READ: begin
                        alu_req.a = tcc_pkg::ADDR_W'(r_rrow);
                        alu_req.b = tcc_pkg::ADDR_W'(r_rcol);
                        n_state   = read_in_range ? tcc_pkg::S_READ : tcc_pkg::S_OFFSET;
                    end
                    default: begin
                        n_state = tcc_pkg::S_OFFSET;
                    end
                endcase
            end
            // registered read data lands here
            tcc_pkg::S_READ: begin
                n_cell  = i_ram_rdata;
                n_state = tcc_pkg::S_OFFSET;
            end
            // scroll: fetch the cell one row below
            tcc_pkg::S_SCR_RD: begin
                alu_req.b = tcc_pkg::ADDR_W'(tcc_pkg::COLUMNS);
                n_state   = tcc_pkg::S_SCR_WR;
            end
            // scroll: store it one row up
            tcc_pkg::S_SCR_WR: begin
                o_ram.we    = 1'b1;
                o_ram.addr  = r_addr;
                o_ram.wdata = i_ram_rdata;
                n_addr      = alu_sum[tcc_pkg::ADDR_W-1:0];
                n_state     = (r_addr == COPY_LAST) ? tcc_pkg::S_CLEAR : tcc_pkg::S_SCR_RD;
            end
            // blank from the current address to the end of the screen
            tcc_pkg::S_CLEAR: begin
                o_ram.we   = 1'b1;
                o_ram.addr = r_addr;
                n_addr     = alu_sum[tcc_pkg::ADDR_W-1:0];
                if (r_addr == LAST_ADDR) begin
                    n_state = tcc_pkg::S_OFFSET;
                end
            end
            // cursor offset, then present the result word
            tcc_pkg::S_OFFSET: begin
                alu_req.op = tcc_pkg::ALU_MAC;
                alu_req.a  = tcc_pkg::ADDR_W'(r_row);
                alu_req.b  = tcc_pkg::ADDR_W'(r_col);
                n_off      = alu_sum[tcc_pkg::OFFSET_W-1:0];
                n_valid    = 1'b1;
                n_state    = tcc_pkg::S_IDLE;
            end
            default: begin
                n_state = tcc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy          = (r_state != tcc_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_cursor_column = r_col;
    assign o_cursor_row    = r_row;
    assign o_cursor_offset = r_off;
    assign o_cell_value    = r_cell;

endmodule

`default_nettype wire

// ----- rtl/text_console_cursor_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Text console with an 80 x 25 screen of 16-bit cells held in a single-port
// RAM, and a cursor. After reset the block is busy while it blanks every
// cell, one per cycle. A word is taken when start is high and busy is low;
// its result appears on the output ports for one cycle with o_valid high
// and must be taken then, as it cannot be held off. A put that does not
// scroll, an unused action and a read off the screen go from idle through
// the execute and offset states and back to idle, where the strobe shows;
// a read on the screen adds a state for the RAM's registered read. A clear
// blanks every cell before the offset state. A put that scrolls copies
// rows 1 to 24 up one row, alternating read and write on the one RAM
// port, and then blanks the bottom row one cell a cycle.
// Every address comes from one shared add / multiply-add unit stepped by
// the sequencer. A new word may be started in the cycle that shows the
// previous result.
module text_console_cursor_engine (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [tcc_pkg::ACT_W-1:0]      i_action,
    input  wire logic [tcc_pkg::CHAR_W-1:0]     i_char_code,
    input  wire logic [tcc_pkg::ROW_W-1:0]      i_read_row,
    input  wire logic [tcc_pkg::COL_W-1:0]      i_read_column,
    output logic                                o_valid,
    output logic [tcc_pkg::COL_W-1:0]           o_cursor_column,
    output logic [tcc_pkg::ROW_W-1:0]           o_cursor_row,
    output logic [tcc_pkg::OFFSET_W-1:0]        o_cursor_offset,
    output logic [tcc_pkg::CELL_W-1:0]          o_cell_value
);

    tcc_pkg::t_ram_req                 ram_req;
    logic [tcc_pkg::CELL_W-1:0]        ram_rdata;

    // sequencer with the shared address unit
    tcc_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .i_ram_rdata     (ram_rdata),
        .o_ram           (ram_req),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_offset (o_cursor_offset),
        .o_cell_value    (o_cell_value)
    );

    // screen memory
    tcc_ram #(
        .WIDTH (tcc_pkg::CELL_W),
        .DEPTH (tcc_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // a result is shown only while the block is free
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not start the sequencer");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_cursor_column < tcc_pkg::COL_W'(tcc_pkg::COLUMNS)) &&
                     (o_cursor_row < tcc_pkg::ROW_W'(tcc_pkg::ROWS))))
        else $error("cursor reported off screen");

endmodule

`default_nettype wire
